FILE: design/ddwpm_pkg.sv
// shared types and constants of the differential drive wheel pwm mapper
`timescale 1ns / 1ps

package ddwpm_pkg;

    typedef enum logic [2:0] {
        CFG_SPEED_GAIN    = 3'd0,
        CFG_TURN_GAIN     = 3'd1,
        CFG_LEFT_RPM_MIN  = 3'd2,
        CFG_LEFT_RPM_MAX  = 3'd3,
        CFG_RIGHT_RPM_MIN = 3'd4,
        CFG_RIGHT_RPM_MAX = 3'd5,
        CFG_VOLT_MIN_MV   = 3'd6,
        CFG_VOLT_MAX_MV   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } dir_t;

    localparam int CFG_W  = 16;
    localparam int ADDR_W = 3;

    localparam logic [15:0] RST_SPEED_GAIN = 16'd5215;
    localparam logic [15:0] RST_TURN_GAIN  = 16'd2560;
    localparam logic [15:0] RST_RPM_MIN    = 16'd160;
    localparam logic [15:0] RST_RPM_MAX    = 16'd1600;
    localparam logic [15:0] RST_VOLT_MIN   = 16'd3000;
    localparam logic [15:0] RST_VOLT_MAX   = 16'd12000;

    localparam int DEF_BATTERY_MV = 12000;
    localparam int DEF_PWM_FULL   = 4095;

    // 2^27 * 125 is the rpm unit, half of it for rounding
    localparam logic [51:0] HALF_UNIT = 52'd8388608000;
    // ceil(2^31 / 125), exact for quotients of values below 2^23
    localparam logic [47:0] RECIP_125 = 48'd17179870;

    localparam int PWM_W    = 12;
    localparam int RPM_W    = 20;
    localparam int MAG_W    = 17;
    localparam int PWM_FIELD_MAX = 4095;

    localparam logic [RPM_W-1:0] RPM_POS_MAX = 20'd524287;
    localparam logic [RPM_W-1:0] RPM_NEG_MAG = 20'd524288;

endpackage

FILE: design/ddwpm_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps

module ddwpm_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int QW = 20,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);

    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic          vld_reg  [0:QW];
    logic [CW-1:0] rem_reg  [0:QW];
    logic [DW-1:0] dsr_reg  [0:QW];
    logic [QW-1:0] quo_reg  [0:QW];
    logic          ovf_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= CW'(num);
            dsr_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= CW'(num) >= (CW'(den) << QW);
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int B = QW - k;
        logic [CW-1:0] sub;
        logic          hit;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        always_comb
        begin
            sub      = CW'(dsr_reg[k-1]) << B;
            hit      = !ovf_reg[k-1] && (rem_reg[k-1] >= sub);
            rem_next = hit ? rem_reg[k-1] - sub : rem_reg[k-1];
            quo_next = quo_reg[k-1];
            quo_next[B] = hit;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                dsr_reg[k]  <= dsr_reg[k-1];
                quo_reg[k]  <= quo_next;
                ovf_reg[k]  <= ovf_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

FILE: design/diff_drive_wheel_pwm_mapper.sv
// top level: body command to wheel direction, pwm and scaled rpm
`timescale 1ns / 1ps

// Takes one body command (linear speed, turn rate) per transaction and returns
// direction, pwm compare value and scaled 1/16 rpm for both wheels. The block
// is a single pipeline; a new transaction is taken every cycle unless the
// output stalls, and results leave in order. The depth is set mostly by two
// rows of bit-per-stage dividers, one per wheel, 21 stages for the common wheel scaling and 13 for the pwm value.
// Backpressure on the master side stalls the whole pipeline. Configuration
// registers are written through cfg_we/cfg_addr/cfg_wdata; the user must do so
// only while no transaction is in flight, which the block does not enforce.
module diff_drive_wheel_pwm_mapper #(
    parameter int BATTERY_MV = ddwpm_pkg::DEF_BATTERY_MV,
    parameter int PWM_FULL   = ddwpm_pkg::DEF_PWM_FULL
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ddwpm_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [ddwpm_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // lin_speed, turn_rate
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // left_dir, left_pwm, right_dir, right_pwm, left_rpm_out, right_rpm_out, pad
    output logic [71:0]                   m_tdata
);

    import ddwpm_pkg::*;

    localparam int PF_W = $clog2(PWM_FULL + 1);
    localparam int BM_W = $clog2(BATTERY_MV + 1);
    localparam int N2_W = 38 + PF_W;
    localparam int D2_W = 16 + BM_W;
    localparam logic [PWM_W-1:0] PWM_CAP =
        PWM_W'((PWM_FULL > PWM_FIELD_MAX) ? PWM_FIELD_MAX : PWM_FULL);

    // configuration
    logic [15:0] speed_gain_reg, turn_gain_reg;
    logic [15:0] rpm_min_reg [2];
    logic [15:0] rpm_max_reg [2];
    logic [15:0] volt_min_reg, volt_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg <= RST_SPEED_GAIN;
            turn_gain_reg  <= RST_TURN_GAIN;
            rpm_min_reg[0] <= RST_RPM_MIN;
            rpm_max_reg[0] <= RST_RPM_MAX;
            rpm_min_reg[1] <= RST_RPM_MIN;
            rpm_max_reg[1] <= RST_RPM_MAX;
            volt_min_reg   <= RST_VOLT_MIN;
            volt_max_reg   <= RST_VOLT_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_SPEED_GAIN:    speed_gain_reg <= cfg_wdata;
                CFG_TURN_GAIN:     turn_gain_reg  <= cfg_wdata;
                CFG_LEFT_RPM_MIN:  rpm_min_reg[0] <= cfg_wdata;
                CFG_LEFT_RPM_MAX:  rpm_max_reg[0] <= cfg_wdata;
                CFG_RIGHT_RPM_MIN: rpm_min_reg[1] <= cfg_wdata;
                CFG_RIGHT_RPM_MAX: rpm_max_reg[1] <= cfg_wdata;
                CFG_VOLT_MIN_MV:   volt_min_reg   <= cfg_wdata;
                CFG_VOLT_MAX_MV:   volt_max_reg   <= cfg_wdata;
                default:           speed_gain_reg <= speed_gain_reg;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_vld_reg;

    // stage valids
    logic [9:0] vld_reg;
    logic       div1_vld [2];
    logic       div2_vld [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            vld_reg[1] <= vld_reg[0];
            vld_reg[2] <= vld_reg[1];
            vld_reg[3] <= vld_reg[2];
            vld_reg[4] <= vld_reg[3];
            vld_reg[5] <= vld_reg[4];
            vld_reg[6] <= div1_vld[0] && div1_vld[1];
            vld_reg[7] <= vld_reg[6];
            vld_reg[8] <= vld_reg[7];
            vld_reg[9] <= vld_reg[8];
            out_vld_reg <= div2_vld[0] && div2_vld[1];
        end
    end

    // s1: input products
    logic signed [32:0] s1_p1_reg, s1_p2_reg;
    // s2: v*sg*125 and w*tg*sg
    logic signed [39:0] s2_a_reg;
    logic signed [49:0] s2_b_reg;
    // s3: rim magnitude over 2^27 and sign
    logic [22:0] s3_x_reg [2];
    logic        s3_neg_reg [2];
    // s4: wheel rpm magnitude
    logic [MAG_W-1:0] s4_mag_reg [2];
    logic             s4_neg_reg [2];
    // s5: common factor
    logic [15:0]      s5_num_reg;
    logic [MAG_W-1:0] s5_den_reg;
    logic [MAG_W-1:0] s5_mag_reg [2];
    logic             s5_neg_reg [2];
    // s6: scaled dividend
    logic [33:0]      s6_n_reg [2];
    logic [MAG_W-1:0] s6_d_reg;
    logic             s6_neg_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p1_reg <= $signed(s_tdata[15:0]) * $signed({1'b0, speed_gain_reg});
            s1_p2_reg <= $signed(s_tdata[31:16]) * $signed({1'b0, turn_gain_reg});
            s2_a_reg  <= 40'(s1_p1_reg) * 40'sd125;
            s2_b_reg  <= 50'(s1_p2_reg) * 50'($signed({1'b0, speed_gain_reg}));
        end
    end

    logic signed [51:0] rim_w [2];
    logic        [51:0] rim_m [2];
    logic        [47:0] rec_p [2];

    always_comb
    begin
        rim_w[0] = 52'($signed({s2_a_reg, 11'b0})) - 52'(s2_b_reg);
        rim_w[1] = 52'($signed({s2_a_reg, 11'b0})) + 52'(s2_b_reg);
        for (int i = 0; i < 2; i++)
        begin
            rim_m[i] = (rim_w[i] < 0) ? 52'(-rim_w[i]) : 52'(rim_w[i]);
            rim_m[i] = rim_m[i] + HALF_UNIT;
            rec_p[i] = 48'(s3_x_reg[i]) * RECIP_125;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s3_x_reg[i]   <= rim_m[i][49:27];
                s3_neg_reg[i] <= rim_w[i] < 0;
                s4_mag_reg[i] <= rec_p[i][47:31];
                s4_neg_reg[i] <= s3_neg_reg[i];
            end
        end
    end

    // common factor selection
    logic             lp, rp, up, down, take;
    logic [15:0]      lsel, rsel;
    logic [32:0]      lhs, rhs;
    logic [15:0]      num_next;
    logic [MAG_W-1:0] den_next;

    always_comb
    begin
        lp   = s4_mag_reg[0] != '0;
        rp   = s4_mag_reg[1] != '0;
        up   = (lp && (s4_mag_reg[0] < MAG_W'(rpm_min_reg[0])))
            || (rp && (s4_mag_reg[1] < MAG_W'(rpm_min_reg[1])));
        down = !up && ((lp && (s4_mag_reg[0] > MAG_W'(rpm_max_reg[0])))
            || (rp && (s4_mag_reg[1] > MAG_W'(rpm_max_reg[1]))));
        lsel = up ? rpm_min_reg[0] : rpm_max_reg[0];
        rsel = up ? rpm_min_reg[1] : rpm_max_reg[1];
        lhs  = 33'(rsel) * 33'(s4_mag_reg[0]);
        rhs  = 33'(lsel) * 33'(s4_mag_reg[1]);
        take = !lp || (up ? (lhs > rhs) : (lhs < rhs));
        if (!(up || down))
        begin
            num_next = 16'd1;
            den_next = MAG_W'(1);
        end
        else if (rp && take)
        begin
            num_next = rsel;
            den_next = s4_mag_reg[1];
        end
        else
        begin
            num_next = lsel;
            den_next = s4_mag_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_num_reg <= num_next;
            s5_den_reg <= den_next;
            s6_d_reg   <= s5_den_reg;
            for (int i = 0; i < 2; i++)
            begin
                s5_mag_reg[i] <= s4_mag_reg[i];
                s5_neg_reg[i] <= s4_neg_reg[i];
                s6_n_reg[i]   <= 34'(s5_mag_reg[i]) * 34'(s5_num_reg)
                               + 34'(s5_den_reg >> 1);
                s6_neg_reg[i] <= s5_neg_reg[i];
            end
        end
    end

    // wheel scaling dividers
    logic [RPM_W-1:0] q1 [2];
    logic             q1_ovf [2];
    logic             q1_neg [2];

    for (genvar w = 0; w < 2; w++)
    begin : g_scale
        ddwpm_div #(
            .NW(34),
            .DW(MAG_W),
            .QW(RPM_W),
            .SW(1)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (vld_reg[5]),
            .num      (s6_n_reg[w]),
            .den      (s6_d_reg),
            .side_in  (s6_neg_reg[w]),
            .out_valid(div1_vld[w]),
            .quo      (q1[w]),
            .ovf      (q1_ovf[w]),
            .side_out (q1_neg[w])
        );
    end

    // s7: saturated signed rpm, s8: voltage products, s9: voltage numerator,
    // s10: pwm dividend and divisor
    logic signed [RPM_W-1:0] s7_rpm_reg [2];
    logic signed [33:0]      s8_t1_reg [2];
    logic signed [37:0]      s8_t2_reg [2];
    logic signed [16:0]      s8_d_reg [2];
    logic signed [RPM_W-1:0] s8_rpm_reg [2];
    logic [37:0]             s9_num_reg [2];
    logic [15:0]             s9_den_reg [2];
    logic                    s9_kill_reg [2];
    logic signed [RPM_W-1:0] s9_rpm_reg [2];
    logic [N2_W-1:0]         s10_n_reg [2];
    logic [D2_W-1:0]         s10_d_reg [2];
    logic                    s10_kill_reg [2];
    logic signed [RPM_W-1:0] s10_rpm_reg [2];

    logic signed [RPM_W-1:0] rpm_next [2];
    logic [RPM_W-1:0]        amag [2];
    logic signed [16:0]      dwin [2];
    logic signed [16:0]      dv;
    logic signed [21:0]      ex [2];
    logic signed [38:0]      vnum [2];
    logic [37:0]             numu_next [2];
    logic [15:0]             den9_next [2];
    logic                    kill_next [2];

    always_comb
    begin
        dv = $signed({1'b0, volt_max_reg}) - $signed({1'b0, volt_min_reg});
        for (int i = 0; i < 2; i++)
        begin
            if (q1_neg[i])
            begin
                rpm_next[i] = (q1_ovf[i] || (q1[i] > RPM_NEG_MAG))
                    ? $signed(RPM_NEG_MAG) : $signed(-q1[i]);
            end
            else
            begin
                rpm_next[i] = (q1_ovf[i] || (q1[i] > RPM_POS_MAX))
                    ? $signed(RPM_POS_MAX) : $signed(q1[i]);
            end
            amag[i] = (s7_rpm_reg[i] < 0) ? RPM_W'(-s7_rpm_reg[i])
                                          : RPM_W'(s7_rpm_reg[i]);
            dwin[i] = $signed({1'b0, rpm_max_reg[i]}) - $signed({1'b0, rpm_min_reg[i]});
            ex[i]   = $signed({2'b0, amag[i]}) - $signed({6'b0, rpm_max_reg[i]});

            vnum[i] = 39'(s8_t1_reg[i]) + 39'(s8_t2_reg[i]);
            if (s8_d_reg[i] == 0)
            begin
                vnum[i]      = $signed({23'b0, volt_max_reg});
                den9_next[i] = 16'd1;
            end
            else if (s8_d_reg[i] < 0)
            begin
                vnum[i]      = -vnum[i];
                den9_next[i] = 16'(-s8_d_reg[i]);
            end
            else
            begin
                den9_next[i] = 16'(s8_d_reg[i]);
            end
            kill_next[i] = (s8_rpm_reg[i] == 0) || (vnum[i] <= 0);
            numu_next[i] = kill_next[i] ? '0 : vnum[i][37:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                s7_rpm_reg[i]   <= rpm_next[i];
                s8_t1_reg[i]    <= 34'($signed({1'b0, volt_max_reg})) * 34'(dwin[i]);
                s8_t2_reg[i]    <= 38'(ex[i]) * 38'(dv);
                s8_d_reg[i]     <= dwin[i];
                s8_rpm_reg[i]   <= s7_rpm_reg[i];
                s9_num_reg[i]   <= numu_next[i];
                s9_den_reg[i]   <= den9_next[i];
                s9_kill_reg[i]  <= kill_next[i];
                s9_rpm_reg[i]   <= s8_rpm_reg[i];
                s10_n_reg[i]    <= N2_W'(s9_num_reg[i]) * N2_W'(PWM_FULL);
                s10_d_reg[i]    <= D2_W'(s9_den_reg[i]) * D2_W'(BATTERY_MV);
                s10_kill_reg[i] <= s9_kill_reg[i];
                s10_rpm_reg[i]  <= s9_rpm_reg[i];
            end
        end
    end

    // pwm dividers
    logic [PWM_W-1:0] q2 [2];
    logic             q2_ovf [2];
    logic [RPM_W:0]   q2_side [2];

    for (genvar w = 0; w < 2; w++)
    begin : g_pwm
        ddwpm_div #(
            .NW(N2_W),
            .DW(D2_W),
            .QW(PWM_W),
            .SW(RPM_W + 1)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (vld_reg[9]),
            .num      (s10_n_reg[w]),
            .den      (s10_d_reg[w]),
            .side_in  ({s10_kill_reg[w], s10_rpm_reg[w]}),
            .out_valid(div2_vld[w]),
            .quo      (q2[w]),
            .ovf      (q2_ovf[w]),
            .side_out (q2_side[w])
        );
    end

    // output register
    logic [PWM_W-1:0]        pwm_next [2];
    dir_t                    dir_next [2];
    logic [PWM_W-1:0]        pwm_reg [2];
    dir_t                    dir_reg [2];
    logic [RPM_W-1:0]        rpm_out_reg [2];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (q2_side[i][RPM_W])
            begin
                pwm_next[i] = '0;
            end
            else if (q2_ovf[i] || (q2[i] > PWM_CAP))
            begin
                pwm_next[i] = PWM_CAP;
            end
            else
            begin
                pwm_next[i] = q2[i];
            end
            if (q2_side[i][RPM_W-1:0] == '0)
            begin
                dir_next[i] = DIR_OFF;
            end
            else if (q2_side[i][RPM_W-1])
            begin
                dir_next[i] = DIR_REV;
            end
            else
            begin
                dir_next[i] = DIR_FWD;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 2; i++)
            begin
                pwm_reg[i]     <= pwm_next[i];
                dir_reg[i]     <= dir_next[i];
                rpm_out_reg[i] <= q2_side[i][RPM_W-1:0];
            end
        end
    end

    assign m_tdata = {4'b0, rpm_out_reg[1], rpm_out_reg[0], pwm_reg[1], dir_reg[1],
                      pwm_reg[0], dir_reg[0]};

    a_off_no_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == DIR_OFF) |-> (m_tdata[13:2] == '0))
        else $error("left wheel off with nonzero pwm");

    a_zero_rpm_off: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[67:48] == '0) |-> (m_tdata[15:14] == DIR_OFF))
        else $error("right wheel zero rpm but driven");

    a_pwm_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[13:2] <= PWM_CAP) && (m_tdata[27:16] <= PWM_CAP))
        else $error("pwm above full scale");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule
